// ----- design/mqb_pkg.sv -----
// Shared types, widths and helpers for the masked quaternion blend.
package mqb_pkg;

    localparam int FRAC_BITS  = 14;             // output scale, one = 2^FRAC_BITS
    localparam int CW         = 16;             // quaternion component width
    localparam int WW         = 13;             // weight width, Q0.12
    localparam int W_ONE      = 4096;
    localparam int TW         = 25;             // blend factor, Q0.24, up to 2^24
    localparam int LERP_BITS  = 24;
    localparam int KEEP_SHIFT = 16;
    localparam int NORM_PRE   = 14;
    localparam int NORM_HALF  = 7;
    localparam int PW         = 2 * CW;         // one dot product term
    localparam int DW         = PW + 2;         // dot product sum
    localparam int SBW        = CW + 1;         // sign-corrected overlay
    localparam int DFW        = CW + 2;         // overlay minus base
    localparam int NUMW       = DFW + TW + 1;   // lerp numerator
    localparam int MW         = 24;             // magnitude of interpolated component
    localparam int SQW        = 2 * MW;
    localparam int SUMW       = SQW + 2;
    localparam int XW         = 64;             // square root radicand
    localparam int ROOTW      = XW / 2;
    localparam int REMW       = ROOTW + 2;
    localparam int SQ_STEPS   = XW / 2;
    localparam int QW         = FRAC_BITS + 1;  // quotient never exceeds 2^FRAC_BITS
    localparam int DREMW      = ROOTW + 1;
    localparam int NW         = MW + FRAC_BITS + NORM_HALF + 1;
    localparam int DIV_STEPS  = QW;

    localparam logic signed [CW-1:0] ID_W =
        (FRAC_BITS >= CW - 1) ? CW'(32767) : CW'(1 << FRAC_BITS);

    typedef enum logic [1:0] {
        PATH_BASE = 2'd0,
        PATH_OVER = 2'd1,
        PATH_LERP = 2'd2
    } path_t;

    typedef struct packed {
        logic signed [CW-1:0] base_x;
        logic signed [CW-1:0] base_y;
        logic signed [CW-1:0] base_z;
        logic signed [CW-1:0] base_w;
        logic signed [CW-1:0] over_x;
        logic signed [CW-1:0] over_y;
        logic signed [CW-1:0] over_z;
        logic signed [CW-1:0] over_w;
        logic [WW-1:0]        joint_weight;
    } in_item_t;

    typedef struct packed {
        logic signed [CW-1:0] res_x;
        logic signed [CW-1:0] res_y;
        logic signed [CW-1:0] res_z;
        logic signed [CW-1:0] res_w;
        path_t                path;
    } out_item_t;

    // Everything one item carries down the cell chain.
    typedef struct packed {
        path_t                     path;
        logic [3:0]                neg;
        logic [3:0][MW-1:0]        mag;
        logic [3:0][CW-1:0]        pass;
        logic [XW-1:0]             x;
        logic [REMW-1:0]           rem;
        logic [ROOTW-1:0]          root;
        logic [3:0][DREMW-1:0]     drem;
        logic [3:0][QW-1:0]        dq;
    } lane_t;

    function automatic logic [WW-1:0] clamp_w(input logic [WW-1:0] v);
        return (v > WW'(W_ONE)) ? WW'(W_ONE) : v;
    endfunction

    function automatic logic signed [CW-1:0] sat_c(input logic signed [QW:0] v);
        if (int'(v) > 32767)
            return CW'(32767);
        if (int'(v) < -32768)
            return CW'(-32768);
        return CW'(v);
    endfunction

endpackage

// ----- design/mqb_front.sv -----
// Front pipeline: weights, dot product, short-arc lerp, squares and radicand.
module mqb_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [mqb_pkg::WW-1:0] layer_weight,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  mqb_pkg::in_item_t      up_item,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output mqb_pkg::lane_t         dn_lane
);
    import mqb_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;

    // stage 1
    logic signed [CW-1:0] a_in [4];
    logic signed [CW-1:0] b_in [4];
    logic signed [PW-1:0] p_next [4];
    logic [TW-1:0]        t_next;
    logic signed [CW-1:0] a1_reg [4];
    logic signed [CW-1:0] b1_reg [4];
    logic signed [PW-1:0] p1_reg [4];
    logic [TW-1:0]        t1_reg;

    // stage 2
    logic signed [DW-1:0]  dot;
    logic signed [SBW-1:0] sb;
    logic signed [DFW-1:0] d_next [4];
    path_t                 path2_next;
    logic signed [CW-1:0]  a2_reg [4];
    logic signed [DFW-1:0] d2_reg [4];
    logic [CW-1:0]         pass2_reg [4];
    logic [TW-1:0]         t2_reg;
    path_t                 path2_reg;

    // stage 3
    logic signed [NUMW-1:0] num [4];
    logic [NUMW-1:0]        nmag [4];
    logic [NUMW-1:0]        nrnd [4];
    logic [MW-1:0]          mag3_reg [4];
    logic [3:0]             neg3_reg;
    logic [CW-1:0]          pass3_reg [4];
    path_t                  path3_reg;

    // stage 4
    logic [SQW-1:0] sq4_reg [4];
    logic [MW-1:0]  mag4_reg [4];
    logic [3:0]     neg4_reg;
    logic [CW-1:0]  pass4_reg [4];
    path_t          path4_reg;
    logic [SUMW-1:0] sum;

    assign r4       = !v4_reg || dn_ready;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign up_ready = r1;
    assign dn_valid = v4_reg;

    always_comb
    begin
        a_in[0] = up_item.base_x;
        a_in[1] = up_item.base_y;
        a_in[2] = up_item.base_z;
        a_in[3] = up_item.base_w;
        b_in[0] = up_item.over_x;
        b_in[1] = up_item.over_y;
        b_in[2] = up_item.over_z;
        b_in[3] = up_item.over_w;
        t_next  = TW'(clamp_w(up_item.joint_weight)) * TW'(clamp_w(layer_weight));
        for (int i = 0; i < 4; i++)
        begin
            p_next[i] = PW'(a_in[i]) * PW'(b_in[i]);
        end
    end

    always_comb
    begin
        dot = DW'(p1_reg[0]) + DW'(p1_reg[1]) + DW'(p1_reg[2]) + DW'(p1_reg[3]);
        if (t1_reg == '0)
            path2_next = PATH_BASE;
        else if (t1_reg[LERP_BITS])
            path2_next = PATH_OVER;
        else
            path2_next = PATH_LERP;
        sb = '0;
        for (int i = 0; i < 4; i++)
        begin
            sb        = (dot < 0) ? -SBW'(b1_reg[i]) : SBW'(b1_reg[i]);
            d_next[i] = DFW'(sb) - DFW'(a1_reg[i]);
        end
    end

    // r = a + (sb - a) * t, kept 8 bits below the input LSB, round half away
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            num[i]  = (NUMW'(a2_reg[i]) <<< LERP_BITS)
                    + NUMW'(d2_reg[i]) * NUMW'($signed({1'b0, t2_reg}));
            nmag[i] = (num[i] < 0) ? NUMW'(-num[i]) : NUMW'(num[i]);
            nrnd[i] = (nmag[i] + NUMW'(1 << (KEEP_SHIFT - 1))) >> KEEP_SHIFT;
        end
    end

    always_comb
    begin
        sum = SUMW'(sq4_reg[0]) + SUMW'(sq4_reg[1]) + SUMW'(sq4_reg[2])
            + SUMW'(sq4_reg[3]);
        dn_lane      = '0;
        dn_lane.path = path4_reg;
        dn_lane.neg  = neg4_reg;
        for (int i = 0; i < 4; i++)
        begin
            dn_lane.mag[i]  = mag4_reg[i];
            dn_lane.pass[i] = pass4_reg[i];
        end
        dn_lane.x = XW'(sum) << NORM_PRE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= up_valid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
            if (r4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && up_valid)
        begin
            t1_reg <= t_next;
            for (int i = 0; i < 4; i++)
            begin
                a1_reg[i] <= a_in[i];
                b1_reg[i] <= b_in[i];
                p1_reg[i] <= p_next[i];
            end
        end
        if (r2 && v1_reg)
        begin
            t2_reg    <= t1_reg;
            path2_reg <= path2_next;
            for (int i = 0; i < 4; i++)
            begin
                a2_reg[i]    <= a1_reg[i];
                d2_reg[i]    <= d_next[i];
                pass2_reg[i] <= (path2_next == PATH_BASE) ? a1_reg[i] : b1_reg[i];
            end
        end
        if (r3 && v2_reg)
        begin
            path3_reg <= path2_reg;
            for (int i = 0; i < 4; i++)
            begin
                mag3_reg[i]  <= MW'(nrnd[i]);
                neg3_reg[i]  <= num[i] < 0;
                pass3_reg[i] <= pass2_reg[i];
            end
        end
        if (r4 && v3_reg)
        begin
            path4_reg <= path3_reg;
            neg4_reg  <= neg3_reg;
            for (int i = 0; i < 4; i++)
            begin
                sq4_reg[i]   <= SQW'(mag3_reg[i]) * SQW'(mag3_reg[i]);
                mag4_reg[i]  <= mag3_reg[i];
                pass4_reg[i] <= pass3_reg[i];
            end
        end
    end

endmodule

// ----- design/mqb_sqrt_cell.sv -----
// One digit-pair step of the pipelined integer square root.
module mqb_sqrt_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  mqb_pkg::lane_t up_lane,
    output logic           dn_valid,
    input  logic           dn_ready,
    output mqb_pkg::lane_t dn_lane
);
    import mqb_pkg::*;

    logic            valid_reg;
    lane_t           lane_reg;
    lane_t           lane_next;
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;
    logic            take;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_lane  = lane_reg;

    always_comb
    begin
        rem_sh         = {up_lane.rem[REMW-3:0], up_lane.x[XW-1 -: 2]};
        trial          = {up_lane.root, 2'b01};
        take           = rem_sh >= trial;
        lane_next      = up_lane;
        lane_next.x    = up_lane.x << 2;
        lane_next.rem  = take ? rem_sh - trial : rem_sh;
        lane_next.root = {up_lane.root[ROOTW-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            lane_reg <= lane_next;
    end

endmodule

// ----- design/mqb_div_cell.sv -----
// One restoring-division bit step, four lanes side by side.
module mqb_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  mqb_pkg::lane_t up_lane,
    output logic           dn_valid,
    input  logic           dn_ready,
    output mqb_pkg::lane_t dn_lane
);
    import mqb_pkg::*;

    logic             valid_reg;
    lane_t            lane_reg;
    lane_t            lane_next;
    logic [DREMW-1:0] rsh [4];
    logic             ge [4];

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_lane  = lane_reg;

    // the dividend's low bits shift out at the top while quotient bits enter below
    always_comb
    begin
        lane_next = up_lane;
        for (int i = 0; i < 4; i++)
        begin
            rsh[i] = {up_lane.drem[i][DREMW-2:0], up_lane.dq[i][QW-1]};
            ge[i]  = rsh[i] >= {1'b0, up_lane.root};
            lane_next.drem[i] = ge[i] ? rsh[i] - {1'b0, up_lane.root} : rsh[i];
            lane_next.dq[i]   = {up_lane.dq[i][QW-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            lane_reg <= lane_next;
    end

endmodule

// ----- design/masked_quaternion_blend.sv -----
// Top level of the masked quaternion blend: front pipeline, root and divide cell chains.
//
//  channel  direction  handshake           payload
//  src      in         src_valid/src_stall src_item  (in_item_t)
//  res      out        res_valid/res_stall res_item  (out_item_t)
//  cfg      in         cfg_we              cfg_data  (layer weight, Q0.12)
//
// One item is taken per cycle while src_stall is low; the pipeline holds 4 front stages, 32 square
// root cells, one divide set-up stage, 15 divide cells and the output register.
// The length of the two cell chains sets most of that depth.
// Reset clears all valid flags and loads the layer weight with one (4096).
// Every stage holds its item only while the stage after it is full and stalled,
// so empty slots close up and new items keep entering while a result waits.
module masked_quaternion_blend (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [mqb_pkg::WW-1:0] cfg_data,
    input  logic                   src_valid,
    output logic                   src_stall,
    input  mqb_pkg::in_item_t      src_item,
    output logic                   res_valid,
    input  logic                   res_stall,
    output mqb_pkg::out_item_t     res_item
);
    import mqb_pkg::*;

    logic [WW-1:0] layer_weight_reg;

    // square root chain boundaries
    logic  sq_valid [SQ_STEPS+1];
    logic  sq_ready [SQ_STEPS+1];
    lane_t sq_lane  [SQ_STEPS+1];

    // divide chain boundaries
    logic  dv_valid [DIV_STEPS+1];
    logic  dv_ready [DIV_STEPS+1];
    lane_t dv_lane  [DIV_STEPS+1];

    logic          front_ready;
    logic          prep_valid_reg;
    lane_t         prep_reg;
    lane_t         prep_next;
    logic [NW-1:0] nval [4];

    logic       res_valid_reg;
    out_item_t  res_item_reg;
    out_item_t  res_next;
    logic       out_ready;
    lane_t      fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            layer_weight_reg <= WW'(W_ONE);
        else if (cfg_we)
            layer_weight_reg <= cfg_data;
    end

    assign src_stall = !front_ready;

    mqb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .layer_weight (layer_weight_reg),
        .up_valid     (src_valid),
        .up_ready     (front_ready),
        .up_item      (src_item),
        .dn_valid     (sq_valid[0]),
        .dn_ready     (sq_ready[0]),
        .dn_lane      (sq_lane[0])
    );

    // |r| scaled by 2^7: floor square root of the sum of squares times 2^14
    for (genvar g = 0; g < SQ_STEPS; g++)
    begin : g_sqrt
        mqb_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (sq_valid[g]),
            .up_ready (sq_ready[g]),
            .up_lane  (sq_lane[g]),
            .dn_valid (sq_valid[g+1]),
            .dn_ready (sq_ready[g+1]),
            .dn_lane  (sq_lane[g+1])
        );
    end

    // divide set-up: numerator is each component magnitude * 2^(FRAC_BITS+7) plus half the root;
    // the quotient fits QW bits, so the top part already sits below the divisor
    assign sq_ready[SQ_STEPS] = !prep_valid_reg || dv_ready[0];

    always_comb
    begin
        prep_next = sq_lane[SQ_STEPS];
        for (int i = 0; i < 4; i++)
        begin
            nval[i] = (NW'(sq_lane[SQ_STEPS].mag[i]) << (FRAC_BITS + NORM_HALF))
                    + NW'(sq_lane[SQ_STEPS].root >> 1);
            prep_next.drem[i] = DREMW'(nval[i] >> QW);
            prep_next.dq[i]   = nval[i][QW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_valid_reg <= 1'b0;
        else if (sq_ready[SQ_STEPS])
            prep_valid_reg <= sq_valid[SQ_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (sq_ready[SQ_STEPS] && sq_valid[SQ_STEPS])
            prep_reg <= prep_next;
    end

    assign dv_valid[0] = prep_valid_reg;
    assign dv_lane[0]  = prep_reg;

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        mqb_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (dv_valid[g]),
            .up_ready (dv_ready[g]),
            .up_lane  (dv_lane[g]),
            .dn_valid (dv_valid[g+1]),
            .dn_ready (dv_ready[g+1]),
            .dn_lane  (dv_lane[g+1])
        );
    end

    // output register; pass-through paths ignore the arithmetic
    assign out_ready            = !res_valid_reg || !res_stall;
    assign dv_ready[DIV_STEPS]  = out_ready;
    assign fin                  = dv_lane[DIV_STEPS];

    always_comb
    begin
        res_next.path  = fin.path;
        res_next.res_x = fin.pass[0];
        res_next.res_y = fin.pass[1];
        res_next.res_z = fin.pass[2];
        res_next.res_w = fin.pass[3];
        if (fin.path == PATH_LERP)
        begin
            if (fin.root == '0)
            begin
                // blend collapsed to zero length: identity
                res_next.res_x = '0;
                res_next.res_y = '0;
                res_next.res_z = '0;
                res_next.res_w = ID_W;
            end
            else
            begin
                res_next.res_x = sat_c(fin.neg[0] ? -(QW+1)'(fin.dq[0]) : (QW+1)'(fin.dq[0]));
                res_next.res_y = sat_c(fin.neg[1] ? -(QW+1)'(fin.dq[1]) : (QW+1)'(fin.dq[1]));
                res_next.res_z = sat_c(fin.neg[2] ? -(QW+1)'(fin.dq[2]) : (QW+1)'(fin.dq[2]));
                res_next.res_w = sat_c(fin.neg[3] ? -(QW+1)'(fin.dq[3]) : (QW+1)'(fin.dq[3]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (out_ready)
            res_valid_reg <= dv_valid[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && dv_valid[DIV_STEPS])
            res_item_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule
